// ===== design/kmer_hash_bottom_k_sketch_unit_defines.svh =====
// Assertion macros shared by the sketch unit.
`ifndef KMER_HASH_BOTTOM_K_SKETCH_UNIT_DEFINES_SVH
`define KMER_HASH_BOTTOM_K_SKETCH_UNIT_DEFINES_SVH

// Check that a property holds on every rising clock edge outside reset.
`define KHS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

`define KHS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== design/khs_pkg.sv =====
package khs_pkg;

  localparam int unsigned MaxSketch = 1024;
  localparam int unsigned MaxKmer   = 32;
  localparam int unsigned AddrW     = $clog2(MaxSketch);
  localparam int unsigned FillW     = $clog2(MaxSketch + 1);
  localparam int unsigned KeyW      = 53;

  localparam logic [5:0] CfgKmerLength = 6'd0;
  localparam logic [5:0] CfgHashSeed   = 6'd1;
  localparam logic [5:0] CfgSketchSize = 6'd2;
  localparam logic [5:0] CfgRounds     = 6'd3;

  localparam logic OpPush = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic [63:0] FmixC1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FmixC2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HASH, ST_MIX_A, ST_MIX_B, ST_MIX_C, ST_MIX_D, ST_MIX_E,
    ST_SEARCH, ST_SHIFT, ST_READ, ST_OUT
  } khs_state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [KeyW-1:0]  wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  function automatic logic [63:0] fwd_seed(input logic [1:0] b);
    case (b)
      2'd0:    fwd_seed = 64'h3c8bfbb395c60474;
      2'd1:    fwd_seed = 64'h3193c18562a02b4c;
      2'd2:    fwd_seed = 64'h295549f54be24456;
      default: fwd_seed = 64'h20323ed082572324;
    endcase
  endfunction

  function automatic logic [63:0] rev_seed(input logic [1:0] b);
    rev_seed = fwd_seed(b ^ 2'd2);
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] n);
    logic [127:0] d;
    d = {x, x} << n;
    rotl64 = d[127:64];
  endfunction

endpackage

// ===== design/kmer_hash_bottom_k_sketch_unit.sv =====
// Bottom-k sketch of canonical rolling k-mer hashes. Each push beat takes one
// base and each read beat one sorted key index; every input beat yields one
// result beat, and the input stalls until that result has been taken. The
// sorted keys live in one 1024-entry RAM with a registered read. A read beat
// fetches its entry in the read state and then gives the result beat. A push
// hashes the window one base per cycle; a window with an invalid base or too
// few bases then goes straight to the result. A valid window then runs each
// fmix round (each 64-bit multiply is built from three 32x32 partial products,
// one a cycle), forms the key, searches the held keys linearly for the first
// one not below the key, and then runs a shifting pass that moves the larger
// entries up and writes the key if it is inserted; a duplicate, or a key that
// misses the full sketch, is not written. The result beat then holds for one
// cycle plus any output stall. Lowering sketch_size trims the fill at once; no
// clearing pass is needed.
module kmer_hash_bottom_k_sketch_unit
  import khs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [7:0]        base_char_i,
  input  logic              new_sequence_i,
  input  logic [9:0]        entry_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              key_valid_o,
  output logic [KeyW-1:0]   key_value_o,
  output logic              key_inserted_o,
  output logic [FillW-1:0]  fill_count_o,
  output logic              entry_present_o,
  output logic [KeyW-1:0]   entry_value_o
);

  khs_state_e state_q, state_d;

  logic [5:0]       kmer_q;
  logic [63:0]      seed_q;
  logic [10:0]      size_q;
  logic [1:0]       rounds_q;
  logic [FillW-1:0] fill_q;
  logic [63:0]      bases_q;
  logic [31:0]      marks_q;
  logic [5:0]       seen_q;

  logic [5:0]       eff_k;
  logic [FillW-1:0] eff_cap;
  always_comb begin
    eff_k = (kmer_q == 6'd0) ? 6'd1 : (kmer_q > 6'(MaxKmer)) ? 6'(MaxKmer) : kmer_q;
    if (size_q < 11'd2) eff_cap = FillW'(2);
    else if (size_q > 11'(MaxSketch)) eff_cap = FillW'(MaxSketch);
    else eff_cap = FillW'(size_q);
  end

  // working registers
  logic [5:0]       pos_q;
  logic [63:0]      fh_q, rh_q, h_q;
  logic [1:0]       rnd_q;
  logic [KeyW-1:0]  key_q;
  logic [AddrW:0]   idx_q;
  logic [AddrW:0]   sh_q;
  logic             ok_q;
  logic             kv_q, ki_q, ep_q;
  logic [KeyW-1:0]  kval_q, eval_q;
  logic             first_q;
  logic [9:0]       entry_index_q;
  logic [1:0]       mpart_q;
  logic [63:0]      mul_a_q, mul_acc_q;

  mem_req_t         req;
  logic [KeyW-1:0]  rdata;

  khs_store u_store (.clk_i(clk_i), .req_i(req), .rdata_o(rdata));

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign key_valid_o = kv_q;
  assign key_value_o = kval_q;
  assign key_inserted_o = ki_q;
  assign fill_count_o = fill_q;
  assign entry_present_o = ep_q;
  assign entry_value_o = eval_q;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // base decode
  logic [7:0] cu;
  logic       base_ok;
  logic [1:0] code;
  always_comb begin
    cu = base_char_i & 8'hDF;
    base_ok = (cu == 8'h41) || (cu == 8'h43) || (cu == 8'h47) || (cu == 8'h54);
    code = base_ok ? base_char_i[2:1] : 2'd0;
  end

  logic [31:0] kmask;
  assign kmask = (eff_k >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << eff_k) - 32'd1);

  logic [1:0] cur_b;
  assign cur_b = bases_q[2*pos_q[4:0] +: 2];

  logic [63:0] mix_x;
  assign mix_x = h_q ^ (h_q >> 33);

  // one 32x32 multiplier; the low 64 bits of the 64x64 product in three parts
  logic [63:0] mul_c;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  always_comb begin
    mul_c = (state_q == ST_MIX_B) ? FmixC1 : FmixC2;
    case (mpart_q)
      2'd0: begin
        mul_x = mix_x[31:0];
        mul_y = mul_c[31:0];
      end
      2'd1: begin
        mul_x = mul_a_q[31:0];
        mul_y = mul_c[63:32];
      end
      default: begin
        mul_x = mul_a_q[63:32];
        mul_y = mul_c[31:0];
      end
    endcase
    mul_p = 64'(mul_x) * 64'(mul_y);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == OpRead) state_d = ST_READ;
          else state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (pos_q == eff_k - 6'd1) begin
          state_d = ok_q ? ((rounds_q == 2'd0) ? ST_MIX_E : ST_MIX_A) : ST_OUT;
        end
      end
      ST_MIX_A: state_d = ST_MIX_B;
      ST_MIX_B: if (mpart_q == 2'd2) state_d = ST_MIX_C;
      ST_MIX_C: if (mpart_q == 2'd2) state_d = ST_MIX_D;
      ST_MIX_D: state_d = (rnd_q > 2'd1) ? ST_MIX_A : ST_MIX_E;
      ST_MIX_E: state_d = ST_SEARCH;
      ST_SEARCH: begin
        if (!first_q) begin
          if (idx_q >= (AddrW+1)'(fill_q) || rdata >= key_q) begin
            state_d = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (!first_q && (sh_q <= idx_q)) state_d = ST_OUT;
      end
      ST_READ: if (!first_q) state_d = ST_OUT;
      ST_OUT: if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory request
  always_comb begin
    req = '0;
    case (state_q)
      ST_IDLE: req.raddr = entry_index_i;
      ST_SEARCH: req.raddr = (first_q || !(idx_q >= (AddrW+1)'(fill_q)
                             || rdata >= key_q)) ? AddrW'(idx_q + (first_q ? 0 : 1))
                             : AddrW'(idx_q);
      ST_SHIFT: begin
        // fetch the entry for the next slot down, two below the slot being written
        req.raddr = first_q ? AddrW'(sh_q - 1'b1) : AddrW'(sh_q - 2'd2);
        if (!first_q && (sh_q >= idx_q)) begin
          req.we = 1'b1;
          req.waddr = AddrW'(sh_q);
          req.wdata = (sh_q == idx_q) ? key_q : rdata;
        end
      end
      ST_READ: req.raddr = entry_index_q;
      default: req = '0;
    endcase
  end

  logic [AddrW:0] top_slot;
  assign top_slot = (fill_q < eff_cap) ? (AddrW+1)'(fill_q) : (AddrW+1)'(eff_cap - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kmer_q <= 6'd21; seed_q <= '0; size_q <= 11'd1024; rounds_q <= 2'd1;
      fill_q <= '0; bases_q <= '0; marks_q <= '0; seen_q <= '0;
      first_q <= 1'b0; kv_q <= 1'b0; ki_q <= 1'b0; ep_q <= 1'b0;
      pos_q <= '0; rnd_q <= '0; idx_q <= '0; sh_q <= '0; ok_q <= 1'b0;
      fh_q <= '0; rh_q <= '0; h_q <= '0; key_q <= '0;
      kval_q <= '0; eval_q <= '0; entry_index_q <= '0;
      mpart_q <= '0; mul_a_q <= '0; mul_acc_q <= '0;
    end else begin
      state_q <= state_d;
      first_q <= (state_d != state_q);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgKmerLength: kmer_q <= cfg_data_i[5:0];
          CfgHashSeed:   seed_q <= cfg_data_i;
          CfgSketchSize: begin
            size_q <= cfg_data_i[10:0];
            begin : trim
              logic [FillW-1:0] c;
              c = (cfg_data_i[10:0] < 11'd2) ? FillW'(2) :
                  (cfg_data_i[10:0] > 11'(MaxSketch)) ? FillW'(MaxSketch) :
                  FillW'(cfg_data_i[10:0]);
              if (fill_q > c) fill_q <= c;
            end
          end
          CfgRounds: rounds_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: if (in_acc) begin
          kv_q <= 1'b0; ki_q <= 1'b0; ep_q <= 1'b0;
          kval_q <= '0; eval_q <= '0;
          entry_index_q <= entry_index_i;
          pos_q <= '0;
          if (opcode_i == OpPush) begin
            if (new_sequence_i) begin
              bases_q <= {62'd0, code};
              marks_q <= {31'd0, !base_ok};
              seen_q <= 6'd1;
              ok_q <= (eff_k == 6'd1) && base_ok;
            end else begin
              bases_q <= {bases_q[61:0], code};
              marks_q <= {marks_q[30:0], !base_ok};
              if (seen_q < 6'(MaxKmer)) seen_q <= seen_q + 6'd1;
              ok_q <= ((({marks_q[30:0], !base_ok}) & kmask) == 32'd0) &&
                      (((seen_q < 6'(MaxKmer)) ? seen_q + 6'd1 : seen_q) >= eff_k);
            end
          end
        end
        ST_HASH: begin
          pos_q <= pos_q + 6'd1;
          if (pos_q == 6'd0) begin
            fh_q <= fwd_seed(cur_b);
            rh_q <= rotl64(rev_seed(cur_b), eff_k - 6'd1);
          end else begin
            fh_q <= fh_q ^ rotl64(fwd_seed(cur_b), pos_q);
            rh_q <= rh_q ^ rotl64(rev_seed(cur_b), eff_k - 6'd1 - pos_q);
          end
          if (pos_q == eff_k - 6'd1) begin
            rnd_q <= (rounds_q == 2'd3) ? 2'd2 : rounds_q;
            h_q <= '0;
          end
        end
        ST_MIX_A: begin
          if (rnd_q == ((rounds_q == 2'd3) ? 2'd2 : rounds_q))
            h_q <= ((fh_q < rh_q) ? fh_q : rh_q) ^ seed_q;
          else h_q <= h_q ^ seed_q;
        end
        ST_MIX_B, ST_MIX_C: begin
          mpart_q <= (mpart_q == 2'd2) ? 2'd0 : mpart_q + 2'd1;
          case (mpart_q)
            2'd0: begin
              mul_a_q <= mix_x;
              mul_acc_q <= mul_p;
            end
            2'd1: mul_acc_q <= mul_acc_q + {mul_p[31:0], 32'd0};
            default: h_q <= mul_acc_q + {mul_p[31:0], 32'd0};
          endcase
        end
        ST_MIX_D: begin
          h_q <= mix_x;
          rnd_q <= rnd_q - 2'd1;
        end
        ST_MIX_E: begin
          key_q <= (rounds_q == 2'd0) ? KeyW'(((fh_q < rh_q) ? fh_q : rh_q) >> 11)
                                       : KeyW'(h_q >> 11);
          idx_q <= '0;
          kv_q <= 1'b1;
        end
        ST_SEARCH: begin
          kval_q <= key_q;
          if (!first_q) begin
            if (idx_q >= (AddrW+1)'(fill_q) || rdata >= key_q) begin
              if ((idx_q < (AddrW+1)'(fill_q) && rdata == key_q) ||
                  idx_q >= (AddrW+1)'(eff_cap)) begin
                sh_q <= '0;
                idx_q <= (AddrW+1)'(MaxSketch) + 1'b1;
              end else begin
                sh_q <= top_slot;
                ki_q <= 1'b1;
                if (fill_q < eff_cap) fill_q <= fill_q + 1'b1;
              end
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_SHIFT: if (!first_q && sh_q > idx_q) sh_q <= sh_q - 1'b1;
        ST_READ: begin
          ep_q <= ({1'b0, entry_index_q} < (AddrW+1)'(fill_q));
          eval_q <= ({1'b0, entry_index_q} < (AddrW+1)'(fill_q)) ? rdata : '0;
        end
        default: ;
      endcase
    end
  end

  `include "kmer_hash_bottom_k_sketch_unit_defines.svh"

  `KHS_ASSERT(a_fill_cap, clk_i, rst_ni, (fill_q <= FillW'(MaxSketch)))
  `KHS_ASSERT(a_out_once, clk_i, rst_ni, (out_valid_o && !out_stall_i) |=> !out_valid_o)
  `KHS_ASSERT(a_ins_valid, clk_i, rst_ni, (out_valid_o && key_inserted_o) |-> key_valid_o)

endmodule

// ===== design/khs_store.sv =====
module khs_store
  import khs_pkg::*;
(
  input  logic            clk_i,
  input  mem_req_t        req_i,
  output logic [KeyW-1:0] rdata_o
);

  logic [KeyW-1:0] mem [MaxSketch];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule
